>>> src/hhct_pkg.sv
// shared types and codes for the handle hold-count table
`default_nettype none
package hhct_pkg;

  // input item kinds
  localparam logic [1:0] KIND_ACQUIRE = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NULL    = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd3;

  // fixed widths of the result ports
  localparam int unsigned SLOT_BITS  = 10;
  localparam int unsigned TOTAL_BITS = 10;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_FOLD,
    ST_READ,
    ST_CHECK
  } hhct_state_t;

endpackage
`default_nettype wire

>>> src/hhct_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module hhct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/handle_hold_count_table.sv
// top level of the handle hold-count table: sequencer, hash unit and entry store
`default_nettype none
// usage
//   command channel: an item (kind, handle) is taken at a rising edge with start high
//   and busy low; busy stays high while the item is worked on
//   result channel: done is high for exactly one cycle with status, slot, hold_count,
//   occupied_entries and balanced_entries; the receiver cannot stall it, so it must
//   take every transfer in the cycle it is shown
//   config: cfg_we writes cfg_wdata into force_timeout; write only while idle
// handling by item kind, from the accepting edge to the edge that raises done
//   null handle, timed-out acquire and unused kind: answered straight from idle; busy
//   stays low, so one such item can be taken every cycle
//   acquire/release: the shared multiplier folds the handle into its home slot one
//   byte per ST_HASH (reciprocal quotient) and ST_FOLD (remainder) pass, then each
//   probed slot passes ST_READ (registered ram read) and ST_CHECK (compare and write)
//   clear item: one ram write per slot, sweeping every slot of the table
//   busy drops on the edge that raises done, so the next item may follow at once
// reset
//   rst starts a clearing pass over every slot of the entry ram; busy is high for its
//   length and no item is taken, config writes still land
module handle_hold_count_table #(
  parameter int unsigned TABLE_ENTRIES = 1009,
  parameter int unsigned HANDLE_BITS   = 32,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // command channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     kind,
  input  wire logic [HANDLE_BITS-1:0]         handle,
  // result channel
  output logic                                done,
  output logic      [1:0]                     status,
  output logic      [hhct_pkg::SLOT_BITS-1:0] slot,
  output logic signed [COUNT_BITS-1:0]        hold_count,
  output logic      [hhct_pkg::TOTAL_BITS-1:0] occupied_entries,
  output logic      [hhct_pkg::TOTAL_BITS-1:0] balanced_entries,
  // force_timeout register
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_wdata
);

  localparam int unsigned IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int unsigned TOT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ENTRY_W = 1 + HANDLE_BITS + COUNT_BITS;

  // handle is reduced a byte at a time, msb first
  localparam int unsigned CHUNKS   = (HANDLE_BITS + 7) / 8;
  localparam int unsigned PAD_BITS = CHUNKS * 8;
  localparam int unsigned CH_W     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  // rem*256 + byte stays below 256*TABLE_ENTRIES, so the reciprocal quotient is exact
  localparam int unsigned Y_W      = IDX_W + 8;
  localparam int unsigned SHIFT    = Y_W + IDX_W;
  localparam int unsigned R_W      = IDX_W + 10;
  localparam int unsigned PROD_W   = Y_W + R_W;
  localparam logic [R_W-1:0] RECIP = R_W'(((64'd1 << SHIFT) + 64'(TABLE_ENTRIES) - 64'd1)
                                          / 64'(TABLE_ENTRIES));

  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CH_W-1:0]  CHUNK_LAST = CH_W'(CHUNKS - 1);
  localparam logic signed [COUNT_BITS-1:0] CMAX = {1'b0, {(COUNT_BITS - 1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CMIN = {1'b1, {(COUNT_BITS - 1){1'b0}}};

  // sequencer and control state
  hhct_pkg::hhct_state_t state, state_next;
  logic [IDX_W-1:0] clr_cnt, clr_cnt_next;
  logic             clr_item, clr_item_next;
  logic [TOT_W-1:0] occ, occ_next;
  logic [TOT_W-1:0] bal, bal_next;
  logic             force_timeout;
  logic             done_next;

  // work registers of the current item
  logic [1:0]             kind_q, kind_q_next;
  logic [HANDLE_BITS-1:0] handle_q, handle_q_next;
  logic [PAD_BITS-1:0]    hash_sh, hash_sh_next;
  logic [CH_W-1:0]        chunk_cnt, chunk_cnt_next;
  logic [7:0]             quot, quot_next;
  logic [IDX_W-1:0]       rem, rem_next;
  logic [IDX_W-1:0]       idx, idx_next;
  logic [IDX_W-1:0]       probe_cnt, probe_cnt_next;

  // result registers
  logic [1:0]                      res_status, res_status_next;
  logic [hhct_pkg::SLOT_BITS-1:0]  res_slot, res_slot_next;
  logic signed [COUNT_BITS-1:0]    res_count, res_count_next;
  logic [hhct_pkg::TOTAL_BITS-1:0] res_occ, res_occ_next;
  logic [hhct_pkg::TOTAL_BITS-1:0] res_bal, res_bal_next;

  // entry ram
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic                         rd_valid;
  logic [HANDLE_BITS-1:0]       rd_key;
  logic signed [COUNT_BITS-1:0] rd_count;

  // shared hash unit: one byte of handle mod TABLE_ENTRIES per pass through ST_HASH and ST_FOLD
  logic [Y_W-1:0]    hash_y;
  logic [PROD_W-1:0] hash_prod;
  logic [7:0]        hash_q;
  logic [Y_W-1:0]    hash_diff;

  // probe hit and count update
  logic                         hit;
  logic signed [COUNT_BITS-1:0] old_count;
  logic signed [COUNT_BITS-1:0] new_count;
  logic                         old_zero;

  hhct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign {rd_valid, rd_key, rd_count} = ram_rdata;

  // remainder so far shifted up a byte with the next handle byte below it
  assign hash_y    = {rem, hash_sh[PAD_BITS-1 -: 8]};
  // quotient by reciprocal multiplication, then remainder by subtracting quotient * N
  assign hash_prod = PROD_W'(hash_y) * PROD_W'(RECIP);
  assign hash_q    = hash_prod[SHIFT +: 8];
  assign hash_diff = hash_y - Y_W'(quot) * Y_W'(TABLE_ENTRIES);

  // an empty slot ends the probe as well as a matching key
  assign hit       = !rd_valid || (rd_key == handle_q);
  // a slot never claimed reads as count zero
  assign old_count = rd_valid ? rd_count : '0;
  assign old_zero  = rd_valid && (old_count == '0);

  // saturating increment or decrement
  always_comb begin
    new_count = old_count;
    if (kind_q == hhct_pkg::KIND_ACQUIRE) begin
      if (old_count != CMAX) begin
        new_count = old_count + COUNT_BITS'(1);
      end
    end else begin
      if (old_count != CMIN) begin
        new_count = old_count - COUNT_BITS'(1);
      end
    end
  end

  assign busy = (state != hhct_pkg::ST_IDLE);

  // force_timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      force_timeout <= 1'b0;
    end else if (cfg_we) begin
      force_timeout <= cfg_wdata;
    end
  end

  // sequencer state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hhct_pkg::ST_CLEAR;
      clr_cnt  <= '0;
      clr_item <= 1'b0;
      occ      <= '0;
      bal      <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_cnt  <= clr_cnt_next;
      clr_item <= clr_item_next;
      occ      <= occ_next;
      bal      <= bal_next;
      done     <= done_next;
    end
  end

  // work and result registers
  always_ff @(posedge clk) begin
    kind_q     <= kind_q_next;
    handle_q   <= handle_q_next;
    hash_sh    <= hash_sh_next;
    chunk_cnt  <= chunk_cnt_next;
    quot       <= quot_next;
    rem        <= rem_next;
    idx        <= idx_next;
    probe_cnt  <= probe_cnt_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_count  <= res_count_next;
    res_occ    <= res_occ_next;
    res_bal    <= res_bal_next;
  end

  // next state, datapath control and result capture
  always_comb begin
    state_next      = state;
    clr_cnt_next    = clr_cnt;
    clr_item_next   = clr_item;
    occ_next        = occ;
    bal_next        = bal;
    done_next       = 1'b0;
    kind_q_next     = kind_q;
    handle_q_next   = handle_q;
    hash_sh_next    = hash_sh;
    chunk_cnt_next  = chunk_cnt;
    quot_next       = quot;
    rem_next        = rem;
    idx_next        = idx;
    probe_cnt_next  = probe_cnt;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_count_next  = res_count;
    res_occ_next    = res_occ;
    res_bal_next    = res_bal;
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = '0;

    case (state)
      hhct_pkg::ST_CLEAR: begin
        // sweep one slot a cycle back to empty
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
        if (clr_cnt == IDX_LAST) begin
          state_next    = hhct_pkg::ST_IDLE;
          clr_cnt_next  = '0;
          clr_item_next = 1'b0;
          occ_next      = '0;
          bal_next      = '0;
          // only a clear item answers; the pass after reset is silent
          if (clr_item) begin
            done_next       = 1'b1;
            res_status_next = hhct_pkg::STATUS_OK;
            res_slot_next   = '0;
            res_count_next  = '0;
            res_occ_next    = '0;
            res_bal_next    = '0;
          end
        end else begin
          clr_cnt_next = clr_cnt + IDX_W'(1);
        end
      end

      hhct_pkg::ST_IDLE: begin
        if (start) begin
          kind_q_next     = kind;
          handle_q_next   = handle;
          res_slot_next   = '0;
          res_count_next  = '0;
          res_occ_next    = hhct_pkg::TOTAL_BITS'(occ);
          res_bal_next    = hhct_pkg::TOTAL_BITS'(bal);
          res_status_next = hhct_pkg::STATUS_OK;
          case (kind)
            hhct_pkg::KIND_CLEAR: begin
              state_next    = hhct_pkg::ST_CLEAR;
              clr_item_next = 1'b1;
              clr_cnt_next  = '0;
            end
            hhct_pkg::KIND_ACQUIRE, hhct_pkg::KIND_RELEASE: begin
              if (handle == '0) begin
                // null handle, checked ahead of the timeout
                done_next       = 1'b1;
                res_status_next = hhct_pkg::STATUS_NULL;
              end else if (kind == hhct_pkg::KIND_ACQUIRE && force_timeout) begin
                done_next       = 1'b1;
                res_status_next = hhct_pkg::STATUS_TIMEOUT;
              end else begin
                state_next     = hhct_pkg::ST_HASH;
                hash_sh_next   = PAD_BITS'(handle);
                chunk_cnt_next = CHUNK_LAST;
                rem_next       = '0;
              end
            end
            default: begin
              // unused kind: plain ok, nothing touched
              done_next = 1'b1;
            end
          endcase
        end
      end

      hhct_pkg::ST_HASH: begin
        // quotient of the current byte step
        quot_next  = hash_q;
        state_next = hhct_pkg::ST_FOLD;
      end

      hhct_pkg::ST_FOLD: begin
        rem_next     = hash_diff[IDX_W-1:0];
        hash_sh_next = hash_sh << 8;
        if (chunk_cnt == '0) begin
          // home slot found, probe starts there
          idx_next       = hash_diff[IDX_W-1:0];
          probe_cnt_next = '0;
          state_next     = hhct_pkg::ST_READ;
        end else begin
          chunk_cnt_next = chunk_cnt - CH_W'(1);
          state_next     = hhct_pkg::ST_HASH;
        end
      end

      hhct_pkg::ST_READ: begin
        // ram samples idx this cycle
        state_next = hhct_pkg::ST_CHECK;
      end

      hhct_pkg::ST_CHECK: begin
        if (hit) begin
          ram_we    = 1'b1;
          ram_waddr = idx;
          ram_wdata = {1'b1, handle_q, new_count};
          // a fresh key claims the slot; balance tracks entries sitting at zero
          occ_next = rd_valid ? occ : occ + TOT_W'(1);
          if (old_zero && (new_count != '0)) begin
            bal_next = bal - TOT_W'(1);
          end else if (!old_zero && (new_count == '0)) begin
            bal_next = bal + TOT_W'(1);
          end
          done_next       = 1'b1;
          res_status_next = hhct_pkg::STATUS_OK;
          res_slot_next   = hhct_pkg::SLOT_BITS'(idx);
          res_count_next  = new_count;
          res_occ_next    = hhct_pkg::TOTAL_BITS'(occ_next);
          res_bal_next    = hhct_pkg::TOTAL_BITS'(bal_next);
          state_next      = hhct_pkg::ST_IDLE;
        end else if (probe_cnt == IDX_LAST) begin
          // every slot visited with no match and no hole
          done_next       = 1'b1;
          res_status_next = hhct_pkg::STATUS_FULL;
          res_slot_next   = '0;
          res_count_next  = '0;
          res_occ_next    = hhct_pkg::TOTAL_BITS'(occ);
          res_bal_next    = hhct_pkg::TOTAL_BITS'(bal);
          state_next      = hhct_pkg::ST_IDLE;
        end else begin
          // linear probe, wrapping past the last slot
          idx_next       = (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
          probe_cnt_next = probe_cnt + IDX_W'(1);
          state_next     = hhct_pkg::ST_READ;
        end
      end

      default: begin
        state_next = hhct_pkg::ST_CLEAR;
      end
    endcase
  end

  assign status           = res_status;
  assign slot             = res_slot;
  assign hold_count       = res_count;
  assign occupied_entries = res_occ;
  assign balanced_entries = res_bal;

  // a result transfer always lands with the sequencer back at idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == hhct_pkg::ST_IDLE))
    else $error("result shown while sequencer busy");

  // balanced entries are a subset of occupied entries
  a_bal_le_occ: assert property (@(posedge clk) disable iff (rst)
    bal <= occ)
    else $error("balanced total exceeds occupied total");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= TOT_W'(TABLE_ENTRIES))
    else $error("occupied total beyond table size");

  // every check follows a read of the probed slot
  a_check_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == hhct_pkg::ST_CHECK) |-> ($past(state) == hhct_pkg::ST_READ))
    else $error("slot checked without a preceding read");

  a_clear_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == hhct_pkg::KIND_CLEAR) |=> (state == hhct_pkg::ST_CLEAR))
    else $error("clear item did not start a sweep");

endmodule
`default_nettype wire

>>> test/tb_top.sv
// testbench for the handle hold-count table: directed and random transfers
`default_nettype none
module tb_top;

  localparam int unsigned TABLE_ENTRIES = 1009;
  localparam int unsigned HANDLE_BITS   = 32;
  localparam int unsigned COUNT_BITS    = 16;
  localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [15:0] COUNT_MIN = 16'sh8000;
  localparam int unsigned POOL_SIZE = 12;

  // one result as the block should present it
  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot;
    logic [15:0] count;
    logic [9:0]  occupied;
    logic [9:0]  balanced;
  } answer_t;

  // mirror of the table: works out each answer at the transfer and checks results in order
  class hold_count_ledger;
    logic [31:0]        keys [TABLE_ENTRIES];
    bit                 in_use [TABLE_ENTRIES];
    logic signed [15:0] counts [TABLE_ENTRIES];
    int unsigned        occupied_total;
    int unsigned        balanced_total;
    bit                 timeout_forced;
    answer_t            pending_answers [$];
    int unsigned        mismatches;
    int unsigned        tally_kind [4];
    int unsigned        tally_status [4];

    function new();
      wipe();
      timeout_forced = 1'b0;
      mismatches = 0;
      foreach (tally_kind[i]) begin
        tally_kind[i] = 0;
        tally_status[i] = 0;
      end
    endfunction

    function void wipe();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        keys[i] = '0;
        in_use[i] = 1'b0;
        counts[i] = '0;
      end
      occupied_total = 0;
      balanced_total = 0;
    endfunction

    function void note_transfer(logic [1:0] op, logic [31:0] key);
      answer_t            a;
      int unsigned        at;
      int unsigned        steps;
      bit                 hit;
      logic signed [15:0] was_count;
      logic signed [15:0] now_count;
      a = '0;
      tally_kind[op]++;
      if (op == hhct_pkg::KIND_CLEAR) begin
        wipe();
      end else if (op == hhct_pkg::KIND_ACQUIRE || op == hhct_pkg::KIND_RELEASE) begin
        if (key == '0) begin
          a.status = hhct_pkg::STATUS_NULL;
        end else if (op == hhct_pkg::KIND_ACQUIRE && timeout_forced) begin
          a.status = hhct_pkg::STATUS_TIMEOUT;
        end else begin
          at = key % TABLE_ENTRIES;
          hit = 1'b0;
          for (steps = 0; steps < TABLE_ENTRIES && !hit; steps++) begin
            if (!in_use[at] || keys[at] == key) hit = 1'b1;
            else at = (at == TABLE_ENTRIES - 1) ? 0 : at + 1;
          end
          if (!hit) begin
            a.status = hhct_pkg::STATUS_FULL;
          end else begin
            was_count = counts[at];
            if (op == hhct_pkg::KIND_ACQUIRE)
              now_count = (was_count == COUNT_MAX) ? was_count : was_count + 16'sd1;
            else
              now_count = (was_count == COUNT_MIN) ? was_count : was_count - 16'sd1;
            if (!in_use[at]) begin
              in_use[at] = 1'b1;
              keys[at] = key;
              occupied_total++;
            end else if (was_count == 0) begin
              balanced_total--;
            end
            if (now_count == 0) balanced_total++;
            counts[at] = now_count;
            a.slot = at[9:0];
            a.count = now_count;
          end
        end
      end
      a.occupied = occupied_total[9:0];
      a.balanced = balanced_total[9:0];
      tally_status[a.status]++;
      pending_answers.push_back(a);
    endfunction

    function void compare(string what, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [1:0] status, logic [9:0] slot, logic [15:0] count,
                               logic [9:0] occupied, logic [9:0] balanced);
      answer_t a;
      if (pending_answers.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d slot %0d", $time, status, slot);
        mismatches++;
      end else begin
        a = pending_answers.pop_front();
        compare("status", a.status, status);
        compare("slot", a.slot, slot);
        compare("hold_count", $signed(a.count), $signed(count));
        compare("occupied_entries", a.occupied, occupied);
        compare("balanced_entries", a.balanced, balanced);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] kind = '0;
  logic [HANDLE_BITS-1:0] handle = '0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic busy;
  logic done;
  logic [1:0] status;
  logic [hhct_pkg::SLOT_BITS-1:0] slot;
  logic signed [COUNT_BITS-1:0] hold_count;
  logic [hhct_pkg::TOTAL_BITS-1:0] occupied_entries;
  logic [hhct_pkg::TOTAL_BITS-1:0] balanced_entries;

  hold_count_ledger ledger;
  bit gaps_allowed = 1'b0;

  handle_hold_count_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .HANDLE_BITS  (HANDLE_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .kind            (kind),
    .handle          (handle),
    .done            (done),
    .status          (status),
    .slot            (slot),
    .hold_count      (hold_count),
    .occupied_entries(occupied_entries),
    .balanced_entries(balanced_entries),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // generous watchdog, well beyond the slowest correct run
  initial begin
    #60000000;
    $display("Some tests failed");
    $finish;
  end

  // results cannot be held off, so every strobe is taken in its own cycle
  always @(posedge clk) begin
    if (!rst && done)
      ledger.check_result(status, slot, hold_count, occupied_entries, balanced_entries);
  end

  // one item: optional idle burst with junk on the payload, then hold start until taken
  task automatic send_item(input logic [1:0] op, input logic [31:0] key);
    int unsigned gap;
    if (gaps_allowed && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start <= 1'b0;
      repeat (gap) begin
        kind <= 2'($urandom_range(0, 3));
        handle <= HANDLE_BITS'($urandom());
        @(posedge clk);
      end
    end
    start <= 1'b1;
    kind <= op;
    handle <= key;
    do @(posedge clk); while (busy);
    ledger.note_transfer(op, key);
  endtask

  // wait for every expected result and an idle block; returns on a rising edge
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (ledger.pending_answers.size() != 0 || busy);
    @(posedge clk);
  endtask

  task automatic write_timeout_reg(input logic value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.timeout_forced = value;
  endtask

  // a random phase: mostly lock traffic on a small pool of colliding handles, some noise
  task automatic run_phase(input int items, input logic timeout_on, input bit with_gaps);
    logic [31:0] pool [POOL_SIZE];
    int unsigned seed_home;
    int unsigned home;
    int unsigned r;
    int n;
    write_timeout_reg(timeout_on);
    seed_home = $urandom_range(0, TABLE_ENTRIES - 1);
    for (n = 0; n < POOL_SIZE; n++) begin
      case (n % 4)
        0: home = seed_home;                         // shared home slot, probe chain
        1: home = TABLE_ENTRIES - 1;                 // chain that wraps past the last slot
        2: home = (seed_home + 1) % TABLE_ENTRIES;   // neighbour, clusters merge
        default: home = $urandom_range(0, TABLE_ENTRIES - 1);
      endcase
      pool[n] = home + TABLE_ENTRIES * $urandom_range(1, 4000000);
    end
    for (n = 0; n < items; n++) begin
      // idling comes and goes in stretches
      if (n % 25 == 0) gaps_allowed = with_gaps && ($urandom_range(0, 2) != 0);
      r = $urandom_range(0, 99);
      if (r < 40)
        send_item(hhct_pkg::KIND_ACQUIRE, pool[$urandom_range(0, POOL_SIZE - 1)]);
      else if (r < 72)
        send_item(hhct_pkg::KIND_RELEASE, pool[$urandom_range(0, POOL_SIZE - 1)]);
      else if (r < 77)
        send_item($urandom_range(0, 1) ? hhct_pkg::KIND_RELEASE : hhct_pkg::KIND_ACQUIRE, '0);
      else if (r < 82)
        send_item(hhct_pkg::KIND_UNUSED, $urandom());
      else if (r < 84)
        send_item(hhct_pkg::KIND_CLEAR, $urandom());
      else
        send_item($urandom_range(0, 1) ? hhct_pkg::KIND_RELEASE : hhct_pkg::KIND_ACQUIRE,
                  $urandom());
    end
    settle();
  endtask

  initial begin
    int p;
    ledger = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // after the clearing pass that follows reset
    write_timeout_reg(1'b0);

    // directed: null handles, unused kind, counting through zero, collisions and wrap
    send_item(hhct_pkg::KIND_ACQUIRE, '0);
    send_item(hhct_pkg::KIND_RELEASE, '0);
    send_item(hhct_pkg::KIND_UNUSED, '0);
    send_item(hhct_pkg::KIND_UNUSED, 32'd5);
    send_item(hhct_pkg::KIND_ACQUIRE, 32'd1);
    send_item(hhct_pkg::KIND_ACQUIRE, 32'd1);
    send_item(hhct_pkg::KIND_RELEASE, 32'd1);
    send_item(hhct_pkg::KIND_RELEASE, 32'd1);          // back to zero, entry balanced
    send_item(hhct_pkg::KIND_RELEASE, 32'd1);          // below zero
    send_item(hhct_pkg::KIND_RELEASE, 32'd1010);       // first release of a new handle
    send_item(hhct_pkg::KIND_ACQUIRE, 32'd1008);       // last slot
    send_item(hhct_pkg::KIND_ACQUIRE, 32'd2017);       // home on the last slot, wraps to 0
    send_item(hhct_pkg::KIND_ACQUIRE, 32'd1009);       // home slot 0, walks a chain
    send_item(hhct_pkg::KIND_ACQUIRE, 32'hFFFF_FFFF);
    send_item(hhct_pkg::KIND_ACQUIRE, 32'h8000_0000);
    send_item(hhct_pkg::KIND_RELEASE, 32'h5555_5555);
    send_item(hhct_pkg::KIND_ACQUIRE, 32'hAAAA_AAAA);
    // forced timeout: acquires refused, null still wins, releases unaffected
    write_timeout_reg(1'b1);
    send_item(hhct_pkg::KIND_ACQUIRE, 32'd1);
    send_item(hhct_pkg::KIND_ACQUIRE, '0);
    send_item(hhct_pkg::KIND_RELEASE, 32'd1);
    write_timeout_reg(1'b0);
    send_item(hhct_pkg::KIND_CLEAR, 32'hFFFF_FFFF);
    send_item(hhct_pkg::KIND_ACQUIRE, 32'd1);
    send_item(hhct_pkg::KIND_CLEAR, '0);

    // random phases, register rewritten before each, last one without idling
    for (p = 0; p < 7; p++)
      run_phase(97, (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : logic'($urandom_range(0, 1)),
                p < 6);

    repeat (100) @(posedge clk);
    if (ledger.pending_answers.size() != 0)
      $display("%0t: %0d results never arrived", $time, ledger.pending_answers.size());
    $display("covered %0d acquire, %0d release, %0d clear and %0d unused-kind transfers",
             ledger.tally_kind[hhct_pkg::KIND_ACQUIRE],
             ledger.tally_kind[hhct_pkg::KIND_RELEASE],
             ledger.tally_kind[hhct_pkg::KIND_CLEAR],
             ledger.tally_kind[hhct_pkg::KIND_UNUSED]);
    $display("answers: %0d ok, %0d null handle, %0d table full, %0d timed out",
             ledger.tally_status[hhct_pkg::STATUS_OK],
             ledger.tally_status[hhct_pkg::STATUS_NULL],
             ledger.tally_status[hhct_pkg::STATUS_FULL],
             ledger.tally_status[hhct_pkg::STATUS_TIMEOUT]);
    if (ledger.mismatches == 0 && ledger.pending_answers.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
